// ===== sv/lps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_pkg: shared definitions for the lubrication pump sequencer
// Phase codes, register map, reset values and the structs passed between
// the configuration block, the phase core and the top level.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  typedef enum logic [PhaseW-1:0] {
    PH_INIT     = 3'd0,
    PH_DISABLED = 3'd1,
    PH_IDLE     = 3'd2,
    PH_BUILDING = 3'd3,
    PH_LUBING   = 3'd4,
    PH_ERROR    = 3'd5
  } phase_e;

  // Register index, taken from the word address bits of paddr.
  typedef enum logic [1:0] {
    REG_LUBE_EN  = 2'd0,
    REG_INTERVAL = 2'd1,
    REG_TIMEOUT  = 2'd2,
    REG_HOLD     = 2'd3
  } reg_idx_e;

  localparam logic             LubeEnRst   = 1'b1;
  localparam logic [TimeW-1:0] IntervalRst = 32'd3600000;
  localparam logic [TimeW-1:0] TimeoutRst  = 32'd30000;
  localparam logic [TimeW-1:0] HoldRst     = 32'd10000;

  typedef struct packed {
    logic             lube_enabled;
    logic [TimeW-1:0] interval_ms;
    logic [TimeW-1:0] pressure_timeout_ms;
    logic [TimeW-1:0] hold_time_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] time_ms;
    logic             motion_enabled;
    logic             pressure_ok;
  } item_t;

  // Current and next phase reported by the core.
  typedef struct packed {
    phase_e phase_cur;
    phase_e phase_next;
  } stat_t;

endpackage

// ===== sv/lps_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_cfg_regs: APB-style configuration registers
// Holds the enable flag and the three millisecond limits; returns them on reads.
// ----------------------------------------------------------------------------
module lps_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lps_pkg::AddrW-1:0]   paddr,
  input  logic [lps_pkg::DataW-1:0]   pwdata,
  output logic [lps_pkg::DataW-1:0]   prdata,
  output lps_pkg::cfg_t               cfg_o
);

  lps_pkg::cfg_t    cfg_q;
  lps_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx   = lps_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lube_enabled        <= lps_pkg::LubeEnRst;
      cfg_q.interval_ms         <= lps_pkg::IntervalRst;
      cfg_q.pressure_timeout_ms <= lps_pkg::TimeoutRst;
      cfg_q.hold_time_ms        <= lps_pkg::HoldRst;
    end else if (wr_en) begin
      unique case (idx)
        lps_pkg::REG_LUBE_EN:  cfg_q.lube_enabled        <= pwdata[0];
        lps_pkg::REG_INTERVAL: cfg_q.interval_ms         <= pwdata;
        lps_pkg::REG_TIMEOUT:  cfg_q.pressure_timeout_ms <= pwdata;
        lps_pkg::REG_HOLD:     cfg_q.hold_time_ms        <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lps_pkg::REG_LUBE_EN:  prdata = {{(lps_pkg::DataW-1){1'b0}}, cfg_q.lube_enabled};
      lps_pkg::REG_INTERVAL: prdata = cfg_q.interval_ms;
      lps_pkg::REG_TIMEOUT:  prdata = cfg_q.pressure_timeout_ms;
      lps_pkg::REG_HOLD:     prdata = cfg_q.hold_time_ms;
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/lps_phase_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_phase_core: phase machine and timestamp registers
// Steps the phase once per transaction taken from the input register.
// ----------------------------------------------------------------------------
module lps_phase_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           upd_i,
  input  lps_pkg::item_t item_i,
  input  lps_pkg::cfg_t  cfg_i,
  output lps_pkg::stat_t stat_o
);

  lps_pkg::phase_e               phase_q, phase_d;
  logic [lps_pkg::TimeW-1:0]     press_start_q, press_start_d;
  logic [lps_pkg::TimeW-1:0]     lube_start_q, lube_start_d;
  logic [lps_pkg::TimeW-1:0]     last_end_q, last_end_d;
  logic [lps_pkg::TimeW-1:0]     since_end, since_press, since_lube;
  logic [lps_pkg::TimeW-1:0]     now;

  assign now         = item_i.time_ms;
  // Elapsed times wrap modulo 2^32.
  assign since_end   = now - last_end_q;
  assign since_press = now - press_start_q;
  assign since_lube  = now - lube_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= lps_pkg::PH_INIT;
      press_start_q <= '0;
      lube_start_q  <= '0;
      last_end_q    <= '0;
    end else if (upd_i) begin
      phase_q       <= phase_d;
      press_start_q <= press_start_d;
      lube_start_q  <= lube_start_d;
      last_end_q    <= last_end_d;
    end
  end

  always_comb begin
    phase_d       = phase_q;
    press_start_d = press_start_q;
    lube_start_d  = lube_start_q;
    last_end_d    = last_end_q;
    if (phase_q == lps_pkg::PH_ERROR) begin
      phase_d = lps_pkg::PH_ERROR;
    end else if (!cfg_i.lube_enabled || !item_i.motion_enabled) begin
      phase_d = lps_pkg::PH_DISABLED;
    end else begin
      unique case (phase_q)
        lps_pkg::PH_INIT: begin
          press_start_d = now;
          lube_start_d  = now;
          phase_d       = lps_pkg::PH_BUILDING;
        end
        lps_pkg::PH_DISABLED, lps_pkg::PH_IDLE: begin
          if (since_end > cfg_i.interval_ms) begin
            press_start_d = now;
            lube_start_d  = now;
            phase_d       = lps_pkg::PH_BUILDING;
          end else begin
            phase_d = lps_pkg::PH_IDLE;
          end
        end
        lps_pkg::PH_BUILDING: begin
          if (item_i.pressure_ok) begin
            phase_d      = lps_pkg::PH_LUBING;
            lube_start_d = now;
          end else if (since_press > cfg_i.pressure_timeout_ms) begin
            phase_d = lps_pkg::PH_ERROR;
          end
        end
        lps_pkg::PH_LUBING: begin
          if (since_lube > cfg_i.hold_time_ms) begin
            phase_d    = lps_pkg::PH_IDLE;
            last_end_d = now;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat_o.phase_cur  = phase_q;
  assign stat_o.phase_next = phase_d;

endmodule

// ===== sv/lubrication_pump_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lubrication_pump_sequencer: periodic lubrication pump phase sequencer
// Input register, one-pass phase step, output register; one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries a millisecond timestamp
//   and the motion-enabled and pressure-ok flags. Each input transaction
//   produces exactly one output transaction (out_valid_o / out_stall_i) that
//   reports the phase after that step.
//   A transaction lands in the input register; when it moves on, the phase
//   step is applied and the result is loaded into the output register.
//   Throughput is one transaction per cycle while the receiver does not stall,
//   set by the update of the phase and timestamp registers as each item moves.
//   When the receiver stalls a full output register, the input register holds
//   its item and in_stall_o rises once that register is also occupied; no
//   transaction is dropped or repeated.
//   Reset puts the phase in initializing, clears the three timestamps and
//   loads the register defaults (enabled, 3600000, 30000, 10000 ms).
//   Registers are written through the APB-style port at byte address 4*i;
//   the user must write them only while no transaction is in flight; the
//   block itself does not enforce this. The error phase is sticky until reset.
// ----------------------------------------------------------------------------
module lubrication_pump_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lps_pkg::TimeW-1:0]     time_ms_i,
  input  logic                          motion_enabled_i,
  input  logic                          pressure_ok_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lps_pkg::PhaseW-1:0]    phase_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lps_pkg::AddrW-1:0]     paddr,
  input  logic [lps_pkg::DataW-1:0]     pwdata,
  output logic [lps_pkg::DataW-1:0]     prdata,
  output logic                          pready
);

  lps_pkg::cfg_t   cfg;
  lps_pkg::stat_t  stat;
  lps_pkg::item_t  s1_item_q;
  logic            s1_valid_q;
  logic            s1_move;
  logic            in_take;
  lps_pkg::phase_e out_phase_q;
  logic            out_valid_q;

  assign pready = 1'b1;

  lps_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // The item in the input register advances whenever the output register is
  // empty or is being emptied in this cycle.
  assign s1_move    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q.time_ms        <= time_ms_i;
      s1_item_q.motion_enabled <= motion_enabled_i;
      s1_item_q.pressure_ok    <= pressure_ok_i;
    end
  end

  // The phase core updates its state exactly when the item moves into the
  // output register, so the next item already sees the new state.
  lps_phase_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (s1_valid_q && s1_move),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .stat_o (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_move) begin
      out_phase_q <= stat.phase_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign phase_o     = out_phase_q;

  // The error phase is sticky until reset.
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.phase_cur == lps_pkg::PH_ERROR |=> stat.phase_cur == lps_pkg::PH_ERROR)
    else $error("error phase left without reset");

  // Initializing is only ever the reset phase.
  a_no_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.phase_cur != lps_pkg::PH_INIT |=> stat.phase_cur != lps_pkg::PH_INIT)
    else $error("phase returned to initializing");

  // An item that leaves the input register always lands in the output register.
  a_item_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_move |=> out_valid_q)
    else $error("item lost between input and output registers");

  // A disabled configuration forces the disabled phase unless in error.
  a_cfg_disable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_move && !cfg.lube_enabled && stat.phase_cur != lps_pkg::PH_ERROR
    |=> stat.phase_cur == lps_pkg::PH_DISABLED)
    else $error("disabled configuration did not force disabled phase");

endmodule

// ===== sim/tb_lubrication_pump_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lubrication_pump_sequencer: self-checking bench for the pump sequencer
// A queue-fed driver and a clocked monitor exercise the input and output
// channels with random idling on both sides. Register settings are changed
// over the APB-style port between phases and read back. An in-bench phase
// predictor computes the expected phase for every accepted input transaction.
// ----------------------------------------------------------------------------
module tb_lubrication_pump_sequencer;
  import lps_pkg::*;

  localparam int unsigned LongHoldCycles = 300;
  // Generous run limit; a normal run needs only a small fraction of it.
  localparam longint unsigned RunLimitNs = 64'd10_000_000;

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  // Block inputs, all at known values from time zero.
  logic             in_valid_q     = 1'b0;
  logic [TimeW-1:0] time_ms_q      = '0;
  logic             motion_q       = 1'b0;
  logic             pressure_ok_q  = 1'b0;
  logic             out_stall_q    = 1'b0;
  logic             psel           = 1'b0;
  logic             penable        = 1'b0;
  logic             pwrite         = 1'b0;
  logic [AddrW-1:0] paddr          = '0;
  logic [DataW-1:0] pwdata         = '0;

  // Block outputs.
  logic              in_stall_o;
  logic              out_valid_o;
  logic [PhaseW-1:0] phase_o;
  logic [DataW-1:0]  prdata;
  logic              pready;

  lubrication_pump_sequencer i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_q),
    .in_stall_o       (in_stall_o),
    .time_ms_i        (time_ms_q),
    .motion_enabled_i (motion_q),
    .pressure_ok_i    (pressure_ok_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_q),
    .phase_o          (phase_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // --------------------------------------------------------------------------
  // Phase predictor. It keeps its own copy of the phase, the three
  // timestamps and the register settings. Register writes only happen while
  // nothing is in flight, so the settings copy is updated at the write edge.
  // --------------------------------------------------------------------------
  cfg_t             cfg_st   = '{LubeEnRst, IntervalRst, TimeoutRst, HoldRst};
  phase_e           ph_st    = PH_INIT;
  logic [TimeW-1:0] press_t0 = '0;
  logic [TimeW-1:0] lube_t0  = '0;
  logic [TimeW-1:0] last_end = '0;

  // Elapsed time wraps modulo 2^32, like the hardware elapsed times.
  function automatic logic [TimeW-1:0] elapsed(input logic [TimeW-1:0] now,
                                               input logic [TimeW-1:0] since);
    elapsed = now - since;
  endfunction

  function automatic phase_e advance_phase(input item_t it);
    // The error phase is sticky; nothing but reset leaves it.
    if (ph_st == PH_ERROR) return ph_st;
    // Lubrication switched off or motion stopped overrides every other phase.
    if (!cfg_st.lube_enabled || !it.motion_enabled) begin
      ph_st = PH_DISABLED;
      return ph_st;
    end
    case (ph_st)
      PH_INIT: begin
        press_t0 = it.time_ms;
        lube_t0  = it.time_ms;
        ph_st    = PH_BUILDING;
      end
      PH_DISABLED, PH_IDLE: begin
        if (elapsed(it.time_ms, last_end) > cfg_st.interval_ms) begin
          press_t0 = it.time_ms;
          lube_t0  = it.time_ms;
          ph_st    = PH_BUILDING;
        end else begin
          ph_st = PH_IDLE;
        end
      end
      PH_BUILDING: begin
        if (it.pressure_ok) begin
          ph_st   = PH_LUBING;
          lube_t0 = it.time_ms;
        end else if (elapsed(it.time_ms, press_t0) > cfg_st.pressure_timeout_ms) begin
          ph_st = PH_ERROR;
        end
      end
      PH_LUBING: begin
        if (elapsed(it.time_ms, lube_t0) > cfg_st.hold_time_ms) begin
          ph_st    = PH_IDLE;
          last_end = it.time_ms;
        end
      end
      default: ;
    endcase
    return ph_st;
  endfunction

  // --------------------------------------------------------------------------
  // Shared bench state.
  // --------------------------------------------------------------------------
  item_t            stim_items[$];      // input transactions not yet driven
  phase_e           pending_phases[$];  // predicted phases not yet returned
  int unsigned      n_queued    = 0;
  int unsigned      n_accepted  = 0;
  int unsigned      n_checked   = 0;
  int unsigned      n_errors    = 0;
  int unsigned      n_settings  = 0;
  int unsigned      phase_hits[8];
  bit               in_taken    = 1'b0;
  bit               out_taken   = 1'b0;
  bit               tx_tight    = 1'b0;
  bit               rx_tight    = 1'b0;
  int unsigned      hold_reqs   = 0;
  logic [TimeW-1:0] gen_time    = '0;

  // A tight side never idles; otherwise a random idle gap is drawn per transaction.
  function automatic int unsigned draw_gap(input bit tight);
    return tight ? 0 : $urandom_range(0, 10);
  endfunction

  // --------------------------------------------------------------------------
  // Driver. Inputs change on the falling edge. The payload is held until the
  // transaction is accepted, and valid is only ever lowered once it is.
  // --------------------------------------------------------------------------
  int unsigned tx_wait = 0;

  always @(negedge clk_i) begin : driver
    item_t cur;
    if (!in_valid_q || in_taken) begin
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid_q <= 1'b0;
      end else if (stim_items.size() > 0) begin
        cur = stim_items.pop_front();
        time_ms_q     <= cur.time_ms;
        motion_q      <= cur.motion_enabled;
        pressure_ok_q <= cur.pressure_ok;
        in_valid_q    <= 1'b1;
        tx_wait = draw_gap(tx_tight);
      end else begin
        in_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. A fresh stall count is drawn after every accepted result. A
  // long hold-off, requested by the stimulus, is counted down here so that
  // the block fills up and stalls its input while the driver keeps offering.
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  int unsigned hold_seen  = 0;

  always @(negedge clk_i) begin : receiver
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = LongHoldCycles;
    end
    if (out_taken) stall_left = draw_gap(rx_tight);
    if (hold_left > 0) begin
      hold_left--;
      out_stall_q <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_q <= 1'b1;
    end else begin
      out_stall_q <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Both channels are sampled on the rising edge. The returned
  // phase is checked against the oldest prediction before a prediction for
  // a transaction accepted on the same edge is added.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    phase_e exp_ph;
    in_taken  = rst_ni && in_valid_q && !in_stall_o;
    out_taken = rst_ni && out_valid_o && !out_stall_q;
    if (out_taken) begin
      if (pending_phases.size() == 0) begin
        $error("phase: result with no prediction waiting, got %0d", phase_o);
        n_errors++;
      end else begin
        exp_ph = pending_phases.pop_front();
        n_checked++;
        phase_hits[exp_ph]++;
        if (phase_o !== exp_ph) begin
          $error("phase mismatch: expected %0d, got %0d", exp_ph, phase_o);
          n_errors++;
        end
      end
    end
    if (in_taken) begin
      n_accepted++;
      pending_phases.push_back(advance_phase('{time_ms_q, motion_q, pressure_ok_q}));
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic push_item(input logic [TimeW-1:0] t, input logic motion,
                           input logic pok);
    stim_items.push_back('{t, motion, pok});
    n_queued++;
  endtask

  // Waits until every queued transaction is accepted and every result has
  // come back, then lets the input and output registers settle before any write.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (n_accepted != n_queued || pending_phases.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  // Register write with a setup and an access phase, then a read-back of the
  // same register. lube_enabled keeps only its lowest bit.
  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] val);
    logic [DataW-1:0] want;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_LUBE_EN:  cfg_st.lube_enabled        = val[0];
      REG_INTERVAL: cfg_st.interval_ms         = val;
      REG_TIMEOUT:  cfg_st.pressure_timeout_ms = val;
      REG_HOLD:     cfg_st.hold_time_ms        = val;
      default: ;
    endcase
    want = (idx == REG_LUBE_EN) ? {{(DataW-1){1'b0}}, val[0]} : val;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $error("%s read-back mismatch: expected %0h, got %0h", idx.name(), want, prdata);
      n_errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One random phase: new settings, a run of transactions with small time
  // steps (with some fully random times when wild), and a closing transaction with
  // motion off so that no build in progress carries over into the next
  // settings.
  task automatic run_phase(input logic en, input logic [TimeW-1:0] interval,
                           input logic [TimeW-1:0] timeout,
                           input logic [TimeW-1:0] hold, input int n,
                           input int unsigned dmax, input int unsigned pok_pct,
                           input bit wild, input bit tight_tx, input bit tight_rx,
                           input bit long_hold);
    write_reg(REG_LUBE_EN, en ? 32'h0000_0001 : 32'h0000_0000);
    write_reg(REG_INTERVAL, interval);
    write_reg(REG_TIMEOUT, timeout);
    write_reg(REG_HOLD, hold);
    n_settings++;
    tx_tight = tight_tx;
    rx_tight = tight_rx;
    for (int k = 0; k < n; k++) begin
      if (wild && $urandom_range(0, 3) == 0) gen_time = $urandom();
      else gen_time += $urandom_range(0, dmax);
      push_item(gen_time, $urandom_range(0, 99) < 92, $urandom_range(0, 99) < pok_pct);
    end
    push_item(gen_time, 1'b0, 1'($urandom_range(0, 1)));
    if (long_hold) hold_reqs++;
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [TimeW-1:0] base;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    n_settings = 1;

    // Directed walk with the reset settings: a full cycle with the strict
    // limits hit exactly and one past them.
    push_item(32'd100, 1'b1, 1'b0);       // leaves init, starts a build
    push_item(32'd200, 1'b1, 1'b0);
    push_item(32'd300, 1'b1, 1'b1);       // pressure reached
    push_item(32'd10300, 1'b1, 1'b0);     // hold exactly at the limit
    push_item(32'd10301, 1'b1, 1'b0);     // one past: back to idle
    push_item(32'd10302, 1'b0, 1'b1);     // motion off
    push_item(32'd3610301, 1'b1, 1'b0);   // interval exactly at the limit
    push_item(32'd3610302, 1'b1, 1'b0);   // one past: build starts
    push_item(32'd3640302, 1'b1, 1'b0);   // timeout exactly at the limit
    push_item(32'd3640302, 1'b1, 1'b1);
    wait_drained();

    // Zero interval and hold, no timeout, timestamps wrapping through zero.
    write_reg(REG_INTERVAL, 32'h0000_0000);
    write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(REG_HOLD, 32'h0000_0000);
    n_settings++;
    push_item(32'hFFFF_FFFF, 1'b1, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b1, 1'b1);
    push_item(32'h0000_0000, 1'b1, 1'b0);
    push_item(32'h0000_0005, 1'b1, 1'b0);
    push_item(32'h0000_0006, 1'b1, 1'b1);
    push_item(32'h0000_0006, 1'b1, 1'b0);
    push_item(32'h0000_0007, 1'b1, 1'b0);
    wait_drained();

    // Only bit 0 of lube_enabled counts; upper bits are masked off.
    write_reg(REG_LUBE_EN, 32'hFFFF_FFFE);
    push_item(32'h0000_0009, 1'b1, 1'b1);
    wait_drained();
    write_reg(REG_LUBE_EN, 32'hFFFF_FFFF);
    push_item(32'h0000_0009, 1'b1, 1'b0);
    push_item(32'h8000_0000, 1'b0, 1'b0);
    wait_drained();
    gen_time = 32'hFFFF_F000;

    // Random phases. Timeouts are either disabled or long against the time
    // steps, so no random phase reaches the sticky error.
    run_phase(1'b1, 32'd100, 32'd500, 32'd60, 500, 10, 50, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(1'b1, 32'd0, 32'hFFFF_FFFF, 32'd0, 400, 20, 30, 1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 80, 10, 50,
              1'b1, 1'b0, 1'b0, 1'b0);
    run_phase(1'b1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 120, 10, 50,
              1'b0, 1'b0, 1'b1, 1'b0);
    run_phase(1'b0, 32'd50, 32'd1000, 32'd20, 150, 10, 50, 1'b1, 1'b0, 1'b0, 1'b0);
    // Back-to-back traffic with a long receiver hold-off at the start.
    run_phase(1'b1, 32'd20, 32'd400, 32'd5, 600, 10, 50, 1'b0, 1'b1, 1'b1, 1'b1);

    // Sticky error: zero timeout, start a build, let it time out, then show
    // that neither motion off nor lubrication off leaves the error phase.
    write_reg(REG_INTERVAL, 32'h0000_0000);
    write_reg(REG_TIMEOUT, 32'h0000_0000);
    n_settings++;
    tx_tight = 1'b0;
    rx_tight = 1'b0;
    base = last_end + 32'd7;
    push_item(base, 1'b1, 1'b0);
    push_item(base + 32'd3, 1'b1, 1'b0);
    push_item(base + 32'd4, 1'b0, 1'b1);
    wait_drained();
    write_reg(REG_LUBE_EN, 32'h0000_0000);
    push_item(base + 32'd5, 1'b1, 1'b1);
    wait_drained();
    write_reg(REG_LUBE_EN, 32'h0000_0001);
    write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    for (int k = 0; k < 8; k++) begin
      push_item($urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    wait_drained();
    repeat (10) @(negedge clk_i);

    $display("Summary: %0d transactions checked over %0d register settings, with a long %0s",
             n_checked, n_settings, "receiver hold-off and a sticky timeout error at the end.");
    $display("Phases returned: init %0d, disabled %0d, idle %0d, building %0d, lube %0d, err %0d",
             phase_hits[PH_INIT], phase_hits[PH_DISABLED], phase_hits[PH_IDLE],
             phase_hits[PH_BUILDING], phase_hits[PH_LUBING], phase_hits[PH_ERROR]);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    #(RunLimitNs);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
